/* src/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int PRIO_W       = 8;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  typedef struct packed {
    logic [PRIO_W-1:0]         prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
    logic [OCC_W-1:0]          occupancy;
  } res_t;

endpackage

/* src/spq_ram.sv */
`timescale 1ns / 1ps

module spq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/spq_seq.sv */
`timescale 1ns / 1ps

module spq_seq #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        action_i,
  input  logic [spq_pkg::PRIO_W-1:0]  prio_i,
  input  logic [spq_pkg::VALUE_W-1:0] value_i,
  output logic                        busy_o,
  output logic                        done_o,
  output spq_pkg::res_t               res_o,
  output logic                        we_o,
  output logic [IDX_W-1:0]            waddr_o,
  output spq_pkg::entry_t             wdata_o,
  output logic                        re_o,
  output logic [IDX_W-1:0]            raddr_o,
  input  spq_pkg::entry_t             rdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_DEQ  = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic [2:0]                  state_q, state_d;
  logic [IDX_W-1:0]            head_q, head_d;
  logic [IDX_W-1:0]            tail_q, tail_d;
  logic [IDX_W-1:0]            cur_q, cur_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [CNT_W-1:0]            pos_q, pos_d;
  logic [spq_pkg::PRIO_W-1:0]  prio_q, prio_d;
  logic [spq_pkg::VALUE_W-1:0] val_q, val_d;
  logic [IDX_W-1:0]            cur_prev, head_next, tail_next;
  logic [CNT_W-1:0]            cnt_inc;
  logic                        shift_up;
  spq_pkg::entry_t             new_entry;

  assign cur_prev  = (cur_q == '0) ? LAST_IDX : cur_q - 1'b1;
  assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
  assign cnt_inc   = cnt_q + 1'b1;

  // shared priority comparator: stored entry moves up when strictly larger
  assign shift_up = rdata_i.prio > prio_q;

  assign new_entry.prio  = prio_q;
  assign new_entry.value = val_q;

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    prio_d  = prio_q;
    val_d   = val_q;
    done_o  = 1'b0;
    res_o.status    = spq_pkg::ST_OK;
    res_o.value     = '0;
    res_o.occupancy = spq_pkg::OCC_W'(cnt_q);
    we_o    = 1'b0;
    waddr_o = cur_q;
    wdata_o = new_entry;
    re_o    = 1'b0;
    raddr_o = cur_prev;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          prio_d = prio_i;
          val_d  = value_i;
          if (action_i == spq_pkg::ACT_DEQ) begin
            if (cnt_q == '0) begin
              done_o       = 1'b1;
              res_o.status = spq_pkg::ST_EMPTY;
            end else begin
              re_o    = 1'b1;
              raddr_o = head_q;
              state_d = S_DEQ;
            end
          end else if (cnt_q == FULL_CNT) begin
            done_o       = 1'b1;
            res_o.status = spq_pkg::ST_FULL;
          end else if (cnt_q == '0) begin
            // empty: write straight into the tail slot
            we_o            = 1'b1;
            waddr_o         = tail_q;
            wdata_o.prio    = prio_i;
            wdata_o.value   = value_i;
            tail_d          = tail_next;
            cnt_d           = cnt_inc;
            done_o          = 1'b1;
            res_o.occupancy = spq_pkg::OCC_W'(cnt_inc);
          end else begin
            cur_d   = tail_q;
            pos_d   = cnt_q;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        re_o    = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        we_o = 1'b1;
        if (shift_up) begin
          wdata_o = rdata_i;
          cur_d   = cur_prev;
          pos_d   = pos_q - 1'b1;
          state_d = (pos_q == CNT_W'(1)) ? S_INS : S_RD;
        end else begin
          tail_d          = tail_next;
          cnt_d           = cnt_inc;
          done_o          = 1'b1;
          res_o.occupancy = spq_pkg::OCC_W'(cnt_inc);
          state_d         = S_IDLE;
        end
      end
      S_INS: begin
        we_o            = 1'b1;
        tail_d          = tail_next;
        cnt_d           = cnt_inc;
        done_o          = 1'b1;
        res_o.occupancy = spq_pkg::OCC_W'(cnt_inc);
        state_d         = S_IDLE;
      end
      S_DEQ: begin
        head_d          = head_next;
        cnt_d           = cnt_q - 1'b1;
        done_o          = 1'b1;
        res_o.value     = rdata_i.value;
        res_o.occupancy = spq_pkg::OCC_W'(cnt_q - 1'b1);
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    pos_q  <= pos_d;
    prio_q <= prio_d;
    val_q  <= val_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* src/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Empty dequeue, full enqueue and enqueue into an empty queue finish from idle; dequeue reads
// the head RAM word, then returns it. Enqueue does a RAM read, then a compare and write, for each
// entry it checks, and writes the new word at the front last when every stored entry moves up.
// The result word sits in an output register; the next word is taken once it has left.
// A new word waits until the last one is done, set by the single RAM port pair and comparator.
// Reset (asynchronous, active low) empties the queue; stored entries are not cleared.

module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic [spq_pkg::PRIO_W-1:0]         priority_req_i,
  input  logic signed [spq_pkg::VALUE_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [spq_pkg::STATUS_W-1:0]       status_o,
  output logic signed [spq_pkg::VALUE_W-1:0] out_value_o,
  output logic [spq_pkg::OCC_W-1:0]          occupancy_o
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic            start, busy, done;
  logic            out_valid_q, out_valid_d;
  spq_pkg::res_t   res, res_q;
  logic            we, re;
  logic [IDX_W-1:0] waddr, raddr;
  spq_pkg::entry_t wdata, rdata;
  logic [$bits(spq_pkg::entry_t)-1:0] rdata_raw;

  assign in_stall_o = busy || out_valid_q;
  assign start      = in_valid_i && !in_stall_o;

  spq_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .action_i(action_i),
    .prio_i  (priority_req_i),
    .value_i (value_i),
    .busy_o  (busy),
    .done_o  (done),
    .res_o   (res),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  spq_ram #(
    .WIDTH($bits(spq_pkg::entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  assign rdata = spq_pkg::entry_t'(rdata_raw);

  // hold the result word until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = res_q.status;
  assign out_value_o = res_q.value;
  assign occupancy_o = res_q.occupancy;

endmodule
